[rtl/core/mixed_radix_coordinate_flatten_core_assert.svh]
// Assertion macros for the mixed-radix coordinate flatten core.
// Taken by `include inside the modules that check their own logic.
`ifndef MIXED_RADIX_COORDINATE_FLATTEN_CORE_ASSERT_SVH
`define MIXED_RADIX_COORDINATE_FLATTEN_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MRCF_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MRCF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/mrcf_pkg.sv]
// Shared types, constants and helper functions of the mixed-radix flatten core.
// No dependencies; used by every module in rtl/core.
package mrcf_pkg;

  localparam int COMP_BITS       = 13;
  localparam int FLAT_BITS       = 24;
  localparam int SIZE_BITS       = 14;
  localparam int CNT_BITS        = 2;
  localparam int IDX_BITS        = 3;
  localparam int MAX_WIDTH_DIMS  = 3;
  localparam int MAX_HEIGHT_DIMS = 3;
  localparam int DIV_STEPS       = 4;
  localparam int PASS_STAGES     = FLAT_BITS / DIV_STEPS;
  localparam int NUM_STAGES      = 2 * PASS_STAGES;
  localparam int FA_BITS         = COMP_BITS + SIZE_BITS + 1;
  localparam int FP_BITS         = FA_BITS + SIZE_BITS;
  localparam int FX_BITS         = FP_BITS + 1;

  localparam logic [FLAT_BITS-1:0] FLAT_MAX  = '1;
  localparam logic [COMP_BITS-1:0] COMP_MAX  = '1;
  localparam logic [CNT_BITS-1:0]  CNT_ONE   = CNT_BITS'(1);
  localparam logic [CNT_BITS-1:0]  CNT_TWO   = CNT_BITS'(2);
  localparam logic [CNT_BITS-1:0]  CNT_THREE = CNT_BITS'(3);
  localparam logic [SIZE_BITS-1:0] SIZE_ONE  = SIZE_BITS'(1);

  typedef enum logic [IDX_BITS-1:0] {
    REG_WIDTH_DIM_COUNT  = 3'd0,
    REG_HEIGHT_DIM_COUNT = 3'd1,
    REG_WIDTH_SIZE_A     = 3'd2,
    REG_WIDTH_SIZE_B     = 3'd3,
    REG_WIDTH_SIZE_C     = 3'd4,
    REG_HEIGHT_SIZE_A    = 3'd5,
    REG_HEIGHT_SIZE_B    = 3'd6,
    REG_HEIGHT_SIZE_C    = 3'd7
  } cfg_reg_t;

  typedef logic [COMP_BITS-1:0] comp_t;
  typedef logic [SIZE_BITS-1:0] size_t;

  // Effective configuration seen by the datapath.
  typedef struct packed {
    logic [CNT_BITS-1:0] nw;
    logic [CNT_BITS-1:0] nh;
    size_t wmul1;
    size_t wmul2;
    size_t hmul1;
    size_t hmul2;
    size_t wdiv1;
    size_t wdiv2;
    size_t hdiv1;
    size_t hdiv2;
  } cfg_t;

  // Restoring divider state: partial remainder, dividend/quotient shifter,
  // and the remainder kept from the first pass.
  typedef struct packed {
    size_t                 rem;
    logic [FLAT_BITS-1:0]  quo;
    size_t                 rem1;
  } div_t;

  typedef struct packed {
    logic                  op;
    comp_t [5:0]           cin;
    logic [FA_BITS-1:0]    fa_x;
    logic [FA_BITS-1:0]    fa_y;
    logic [FP_BITS-1:0]    fp_x;
    logic [FP_BITS-1:0]    fp_y;
    logic [FX_BITS-1:0]    fx_x;
    logic [FX_BITS-1:0]    fx_y;
    div_t                  dx;
    div_t                  dy;
  } item_t;

  typedef struct packed {
    comp_t [2:0] c;
    logic        ovf;
  } split_t;

  function automatic logic [CNT_BITS-1:0] eff_count(input logic [CNT_BITS-1:0] r,
                                                    input int limit);
    logic [CNT_BITS-1:0] n;
    n = (r == '0) ? CNT_ONE : r;
    if (int'(n) > limit) n = CNT_BITS'(limit);
    return n;
  endfunction

  function automatic size_t eff_size(input size_t s);
    return (s == '0) ? SIZE_ONE : s;
  endfunction

  // Retire DIV_STEPS quotient bits, most significant first.
  function automatic div_t div_steps(input div_t s, input size_t d);
    logic [SIZE_BITS:0] trial;
    div_t r;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {r.rem, r.quo[FLAT_BITS-1]};
      r.quo = {r.quo[FLAT_BITS-2:0], 1'b0};
      if (trial >= {1'b0, d}) begin
        trial    = trial - {1'b0, d};
        r.quo[0] = 1'b1;
      end
      r.rem = trial[SIZE_BITS-1:0];
    end
    return r;
  endfunction

  function automatic comp_t sat_quo(input logic [FLAT_BITS-1:0] v);
    return (v > FLAT_BITS'(COMP_MAX)) ? COMP_MAX : v[COMP_BITS-1:0];
  endfunction

  function automatic comp_t sat_rem(input size_t v);
    return (v > SIZE_BITS'(COMP_MAX)) ? COMP_MAX : v[COMP_BITS-1:0];
  endfunction

  // Map divider results to components: pass-two quotient is the most
  // significant, pass-two remainder next, pass-one remainder least.
  function automatic split_t split_out(input div_t d, input logic [CNT_BITS-1:0] n);
    split_t r;
    r.c[0] = sat_quo(d.quo);
    r.ovf  = d.quo > FLAT_BITS'(COMP_MAX);
    r.c[1] = '0;
    r.c[2] = '0;
    if (n == CNT_TWO) begin
      r.c[1] = sat_rem(d.rem1);
      r.ovf  = r.ovf | (d.rem1 > SIZE_BITS'(COMP_MAX));
    end else if (n == CNT_THREE) begin
      r.c[1] = sat_rem(d.rem);
      r.c[2] = sat_rem(d.rem1);
      r.ovf  = r.ovf | (d.rem > SIZE_BITS'(COMP_MAX)) | (d.rem1 > SIZE_BITS'(COMP_MAX));
    end
    return r;
  endfunction

endpackage

[rtl/core/mrcf_cfg.sv]
// Configuration register file; presents effective counts, multipliers, divisors.
// Depends on mrcf_pkg.
module mrcf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mrcf_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [mrcf_pkg::SIZE_BITS-1:0] cfg_data,
  output mrcf_pkg::cfg_t                cfg
);
  import mrcf_pkg::*;

  logic [CNT_BITS-1:0] wcnt;
  logic [CNT_BITS-1:0] hcnt;
  size_t               wsz_b;
  size_t               wsz_c;
  size_t               hsz_b;
  size_t               hsz_c;
  logic [CNT_BITS-1:0] nw;
  logic [CNT_BITS-1:0] nh;

  always_ff @(posedge clk) begin
    if (rst) begin
      wcnt  <= CNT_ONE;
      hcnt  <= CNT_ONE;
      wsz_b <= SIZE_ONE;
      wsz_c <= SIZE_ONE;
      hsz_b <= SIZE_ONE;
      hsz_c <= SIZE_ONE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH_DIM_COUNT:  wcnt  <= cfg_data[CNT_BITS-1:0];
        REG_HEIGHT_DIM_COUNT: hcnt  <= cfg_data[CNT_BITS-1:0];
        REG_WIDTH_SIZE_B:     wsz_b <= cfg_data;
        REG_WIDTH_SIZE_C:     wsz_c <= cfg_data;
        REG_HEIGHT_SIZE_B:    hsz_b <= cfg_data;
        REG_HEIGHT_SIZE_C:    hsz_c <= cfg_data;
        // the most significant size never enters the arithmetic
        REG_WIDTH_SIZE_A, REG_HEIGHT_SIZE_A: ;
      endcase
    end
  end

  always_comb begin
    nw        = eff_count(wcnt, MAX_WIDTH_DIMS);
    nh        = eff_count(hcnt, MAX_HEIGHT_DIMS);
    cfg.nw    = nw;
    cfg.nh    = nh;
    cfg.wmul1 = eff_size(wsz_b);
    cfg.wmul2 = eff_size(wsz_c);
    cfg.hmul1 = eff_size(hsz_b);
    cfg.hmul2 = eff_size(hsz_c);
    cfg.wdiv1 = (nw == CNT_THREE) ? eff_size(wsz_c) :
                (nw == CNT_TWO)   ? eff_size(wsz_b) : SIZE_ONE;
    cfg.wdiv2 = (nw == CNT_THREE) ? eff_size(wsz_b) : SIZE_ONE;
    cfg.hdiv1 = (nh == CNT_THREE) ? eff_size(hsz_c) :
                (nh == CNT_TWO)   ? eff_size(hsz_b) : SIZE_ONE;
    cfg.hdiv2 = (nh == CNT_THREE) ? eff_size(hsz_b) : SIZE_ONE;
  end

endmodule

[rtl/core/mrcf_stage.sv]
// One pipeline stage: four divider steps per axis plus its share of the fold.
// Depends on mrcf_pkg.
module mrcf_stage #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  mrcf_pkg::cfg_t  cfg,
  input  logic            up_valid,
  input  mrcf_pkg::item_t up_item,
  output logic            up_ready,
  output logic            dn_valid,
  output mrcf_pkg::item_t dn_item,
  input  logic            dn_ready
);
  import mrcf_pkg::*;

  logic  valid;
  item_t item;
  item_t item_next;
  div_t  dxs;
  div_t  dys;
  size_t wd;
  size_t hd;
  logic [COMP_BITS+SIZE_BITS-1:0] px;
  logic [COMP_BITS+SIZE_BITS-1:0] py;

  always_comb begin
    item_next = up_item;
    dxs       = up_item.dx;
    dys       = up_item.dy;
    px        = up_item.cin[0] * cfg.wmul1;
    py        = up_item.cin[3] * cfg.hmul1;
    // second pass starts on the first-pass quotient; keep its remainder
    if (STAGE == PASS_STAGES) begin
      dxs.rem1 = dxs.rem;
      dxs.rem  = '0;
      dys.rem1 = dys.rem;
      dys.rem  = '0;
    end
    wd = (STAGE < PASS_STAGES) ? cfg.wdiv1 : cfg.wdiv2;
    hd = (STAGE < PASS_STAGES) ? cfg.hdiv1 : cfg.hdiv2;
    item_next.dx = div_steps(dxs, wd);
    item_next.dy = div_steps(dys, hd);

    if (STAGE == 0) begin
      item_next.fa_x = FA_BITS'(px);
      item_next.fa_y = FA_BITS'(py);
    end else if (STAGE == 1) begin
      item_next.fa_x = (cfg.nw == CNT_ONE) ? FA_BITS'(up_item.cin[0]) :
                       up_item.fa_x + FA_BITS'(up_item.cin[1]);
      item_next.fa_y = (cfg.nh == CNT_ONE) ? FA_BITS'(up_item.cin[3]) :
                       up_item.fa_y + FA_BITS'(up_item.cin[4]);
    end else if (STAGE == 2) begin
      item_next.fp_x = up_item.fa_x * cfg.wmul2;
      item_next.fp_y = up_item.fa_y * cfg.hmul2;
    end else if (STAGE == 3) begin
      item_next.fx_x = (cfg.nw == CNT_THREE) ?
                       FX_BITS'(up_item.fp_x) + FX_BITS'(up_item.cin[2]) :
                       FX_BITS'(up_item.fa_x);
      item_next.fx_y = (cfg.nh == CNT_THREE) ?
                       FX_BITS'(up_item.fp_y) + FX_BITS'(up_item.cin[5]) :
                       FX_BITS'(up_item.fa_y);
    end
  end

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

endmodule

[rtl/core/mixed_radix_coordinate_flatten_core.sv]
// Top level of the mixed-radix coordinate flatten/unflatten core.
// Depends on mrcf_pkg, mrcf_cfg, mrcf_stage and the assertion macro header.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------------
//   request  | req_valid / req_stall | op, coord_in_0..5, flat_x_in, flat_y_in
//   result   | res_valid / res_stall | flat_x/y_out, coord_out_0..5, overflow
//   config   | cfg_we                | cfg_index, cfg_data (no wait, no read)
//
// One request enters per cycle unless req_stall is high; each request passes every
// stage and then the output register. The stage count is set by the restoring divider:
// 4 quotient bits per stage, two 24-bit passes per axis (x and y run side by side).
// Reset (rst, synchronous) empties every stage; config registers return to 1.
// A stall on the result side fills bubbles first and then holds every stage.
module mixed_radix_coordinate_flatten_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mrcf_pkg::IDX_BITS-1:0]   cfg_index,
  input  logic [mrcf_pkg::SIZE_BITS-1:0]  cfg_data,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  logic                            op,
  input  logic [mrcf_pkg::COMP_BITS-1:0]  coord_in_0,
  input  logic [mrcf_pkg::COMP_BITS-1:0]  coord_in_1,
  input  logic [mrcf_pkg::COMP_BITS-1:0]  coord_in_2,
  input  logic [mrcf_pkg::COMP_BITS-1:0]  coord_in_3,
  input  logic [mrcf_pkg::COMP_BITS-1:0]  coord_in_4,
  input  logic [mrcf_pkg::COMP_BITS-1:0]  coord_in_5,
  input  logic [mrcf_pkg::FLAT_BITS-1:0]  flat_x_in,
  input  logic [mrcf_pkg::FLAT_BITS-1:0]  flat_y_in,
  output logic                            res_valid,
  input  logic                            res_stall,
  output logic [mrcf_pkg::FLAT_BITS-1:0]  flat_x_out,
  output logic [mrcf_pkg::FLAT_BITS-1:0]  flat_y_out,
  output logic [mrcf_pkg::COMP_BITS-1:0]  coord_out_0,
  output logic [mrcf_pkg::COMP_BITS-1:0]  coord_out_1,
  output logic [mrcf_pkg::COMP_BITS-1:0]  coord_out_2,
  output logic [mrcf_pkg::COMP_BITS-1:0]  coord_out_3,
  output logic [mrcf_pkg::COMP_BITS-1:0]  coord_out_4,
  output logic [mrcf_pkg::COMP_BITS-1:0]  coord_out_5,
  output logic                            overflow
);
  import mrcf_pkg::*;
`include "mixed_radix_coordinate_flatten_core_assert.svh"

  cfg_t               cfg;
  item_t              stg_item [NUM_STAGES+1];
  logic [NUM_STAGES:0] stg_valid;
  logic [NUM_STAGES:0] stg_ready;
  item_t              last;
  split_t             sx;
  split_t             sy;
  logic               fovf_x;
  logic               fovf_y;
  logic               sat_any;
  logic               flat_any;
  logic               coord_any;

  mrcf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Load the request into the head of the pipe; dividers start with a
  // zero remainder and the flat value in the shifter.
  always_comb begin
    stg_item[0]         = '0;
    stg_item[0].op      = op;
    stg_item[0].cin[0]  = coord_in_0;
    stg_item[0].cin[1]  = coord_in_1;
    stg_item[0].cin[2]  = coord_in_2;
    stg_item[0].cin[3]  = coord_in_3;
    stg_item[0].cin[4]  = coord_in_4;
    stg_item[0].cin[5]  = coord_in_5;
    stg_item[0].dx.quo  = flat_x_in;
    stg_item[0].dy.quo  = flat_y_in;
  end

  assign stg_valid[0] = req_valid;
  assign req_stall    = !stg_ready[0];

  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
    mrcf_stage #(.STAGE(k)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .up_valid (stg_valid[k]),
      .up_item  (stg_item[k]),
      .up_ready (stg_ready[k]),
      .dn_valid (stg_valid[k+1]),
      .dn_item  (stg_item[k+1]),
      .dn_ready (stg_ready[k+1])
    );
  end

  // Output register: advance whenever it is empty or being taken.
  assign stg_ready[NUM_STAGES] = !res_valid || !res_stall;
  assign last                  = stg_item[NUM_STAGES];

  // Saturate and pick the fields for the request's operation.
  always_comb begin
    sx     = split_out(last.dx, cfg.nw);
    sy     = split_out(last.dy, cfg.nh);
    fovf_x = last.fx_x > FX_BITS'(FLAT_MAX);
    fovf_y = last.fx_y > FX_BITS'(FLAT_MAX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (stg_ready[NUM_STAGES]) begin
      res_valid <= stg_valid[NUM_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (stg_ready[NUM_STAGES] && stg_valid[NUM_STAGES]) begin
      if (!last.op) begin
        flat_x_out  <= fovf_x ? FLAT_MAX : last.fx_x[FLAT_BITS-1:0];
        flat_y_out  <= fovf_y ? FLAT_MAX : last.fx_y[FLAT_BITS-1:0];
        coord_out_0 <= '0;
        coord_out_1 <= '0;
        coord_out_2 <= '0;
        coord_out_3 <= '0;
        coord_out_4 <= '0;
        coord_out_5 <= '0;
        overflow    <= fovf_x | fovf_y;
      end else begin
        flat_x_out  <= '0;
        flat_y_out  <= '0;
        coord_out_0 <= sx.c[0];
        coord_out_1 <= sx.c[1];
        coord_out_2 <= sx.c[2];
        coord_out_3 <= sy.c[0];
        coord_out_4 <= sy.c[1];
        coord_out_5 <= sy.c[2];
        overflow    <= sx.ovf | sy.ovf;
      end
    end
  end

  // Summaries of the result fields for the checks below.
  assign sat_any   = flat_x_out == FLAT_MAX || flat_y_out == FLAT_MAX ||
                     coord_out_0 == COMP_MAX || coord_out_1 == COMP_MAX ||
                     coord_out_2 == COMP_MAX || coord_out_3 == COMP_MAX ||
                     coord_out_4 == COMP_MAX || coord_out_5 == COMP_MAX;
  assign flat_any  = flat_x_out != '0 || flat_y_out != '0;
  assign coord_any = coord_out_0 != '0 || coord_out_1 != '0 || coord_out_2 != '0 ||
                     coord_out_3 != '0 || coord_out_4 != '0 || coord_out_5 != '0;

  // Overflow only comes with some field pinned at its maximum.
  `MRCF_ASSERT_NOW(a_ovf_saturated, res_valid && overflow, sat_any, "overflow without saturation")
  // A flatten result never carries coordinates.
  `MRCF_ASSERT_NOW(a_op_exclusive, res_valid && flat_any, !coord_any, "flat and coord both set")
  // Head stage only pushes back when it holds a request.
  `MRCF_ASSERT_NOW(a_stall_needs_item, req_stall, stg_valid[1], "request stalled with empty head stage")
  // A finished request moves into the output register.
  `MRCF_ASSERT_NEXT(a_tail_to_out, stg_valid[NUM_STAGES] && stg_ready[NUM_STAGES], res_valid, "finished request lost")

endmodule

[tb/tb_top.sv]
// Self-checking testbench for mixed_radix_coordinate_flatten_core.
// Depends on mrcf_pkg and the core RTL. It drives requests with random gaps,
// stalls the result side, and checks every result against a directed value or its own predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import mrcf_pkg::*;

  localparam logic OP_FLATTEN   = 1'b0;
  localparam logic OP_UNFLATTEN = 1'b1;
  localparam int   IDLE_LIMIT   = 5000;
  localparam int   PHASES       = 10;
  localparam int   PHASE_ITEMS  = 70;

  typedef struct packed {
    logic                 op;
    comp_t [5:0]          cin;
    logic [FLAT_BITS-1:0] fx;
    logic [FLAT_BITS-1:0] fy;
  } conv_req_t;

  typedef struct packed {
    logic [FLAT_BITS-1:0] fx;
    logic [FLAT_BITS-1:0] fy;
    comp_t [5:0]          c;
    logic                 ovf;
  } conv_res_t;

  typedef struct packed {
    conv_req_t rq;
    logic      typed;
    conv_res_t rs;
  } stim_row_t;

  logic clk, rst;
  logic cfg_we;
  logic [IDX_BITS-1:0]  cfg_index;
  logic [SIZE_BITS-1:0] cfg_data;
  logic req_valid, req_stall, res_valid, res_stall;
  logic op;
  comp_t coord_in_0, coord_in_1, coord_in_2, coord_in_3, coord_in_4, coord_in_5;
  logic [FLAT_BITS-1:0] flat_x_in, flat_y_in, flat_x_out, flat_y_out;
  comp_t coord_out_0, coord_out_1, coord_out_2, coord_out_3, coord_out_4, coord_out_5;
  logic overflow;

  mixed_radix_coordinate_flatten_core uut (.*);

  // Shadow copy of the configuration registers.
  logic [CNT_BITS-1:0]  shadow_wcnt, shadow_hcnt;
  logic [SIZE_BITS-1:0] shadow_wsz [3];
  logic [SIZE_BITS-1:0] shadow_hsz [3];

  conv_res_t pending_results [$];
  conv_res_t next_result;   // expectation of the request on the bus
  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  quiet = 0;           // no idling in the last part of the run

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned shadow_count(logic [CNT_BITS-1:0] r);
    return (r == 0) ? 1 : r;
  endfunction

  function automatic longint unsigned shadow_size(logic [SIZE_BITS-1:0] s);
    return (s == 0) ? 1 : s;
  endfunction

  // Compute the expected result of one request under the shadow config.
  function automatic conv_res_t convert_coord(conv_req_t rq);
    conv_res_t r;
    longint unsigned acc, stride, v, q;
    int unsigned nw, nh, n, base;
    r = '0;
    nw = shadow_count(shadow_wcnt);
    nh = shadow_count(shadow_hcnt);
    for (int g = 0; g < 2; g++) begin
      n = g ? nh : nw;
      base = g ? 3 : 0;
      if (rq.op == OP_FLATTEN) begin
        acc = 0;
        for (int i = 0; i < n; i++)
          acc = acc * shadow_size(g ? shadow_hsz[i] : shadow_wsz[i]) + rq.cin[base+i];
        if (acc > FLAT_MAX) begin
          acc = FLAT_MAX;
          r.ovf = 1;
        end
        if (g) r.fy = FLAT_BITS'(acc); else r.fx = FLAT_BITS'(acc);
      end else begin
        stride = 1;
        for (int i = 0; i < n; i++)
          stride *= shadow_size(g ? shadow_hsz[i] : shadow_wsz[i]);
        v = g ? rq.fy : rq.fx;
        for (int i = 0; i < n; i++) begin
          stride /= shadow_size(g ? shadow_hsz[i] : shadow_wsz[i]);
          q = v / stride;
          v = v % stride;
          if (q > COMP_MAX) begin
            q = COMP_MAX;
            r.ovf = 1;
          end
          r.c[base+i] = COMP_BITS'(q);
        end
      end
    end
    return r;
  endfunction

  // Drain the pipeline, then write one register per cycle.
  task automatic write_config(logic [CNT_BITS-1:0] wc, logic [CNT_BITS-1:0] hc,
                              logic [SIZE_BITS-1:0] ws [3], logic [SIZE_BITS-1:0] hs [3]);
    wait (pending_results.size() == 0);
    repeat (NUM_STAGES + 4) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= REG_WIDTH_DIM_COUNT;  cfg_data <= SIZE_BITS'(wc); @(negedge clk);
    cfg_index <= REG_HEIGHT_DIM_COUNT; cfg_data <= SIZE_BITS'(hc); @(negedge clk);
    cfg_index <= REG_WIDTH_SIZE_A;     cfg_data <= ws[0]; @(negedge clk);
    cfg_index <= REG_WIDTH_SIZE_B;     cfg_data <= ws[1]; @(negedge clk);
    cfg_index <= REG_WIDTH_SIZE_C;     cfg_data <= ws[2]; @(negedge clk);
    cfg_index <= REG_HEIGHT_SIZE_A;    cfg_data <= hs[0]; @(negedge clk);
    cfg_index <= REG_HEIGHT_SIZE_B;    cfg_data <= hs[1]; @(negedge clk);
    cfg_index <= REG_HEIGHT_SIZE_C;    cfg_data <= hs[2]; @(negedge clk);
    cfg_we <= 0;
    shadow_wcnt = wc;
    shadow_hcnt = hc;
    shadow_wsz = ws;
    shadow_hsz = hs;
  endtask

  // Present one request at the falling edge and hold it until accepted.
  task automatic send_request(conv_req_t rq, conv_res_t exp_res);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      req_valid <= 0;
      gap = $urandom_range(1, 16);
      repeat (gap) @(negedge clk);
    end
    op <= rq.op;
    coord_in_0 <= rq.cin[0]; coord_in_1 <= rq.cin[1]; coord_in_2 <= rq.cin[2];
    coord_in_3 <= rq.cin[3]; coord_in_4 <= rq.cin[4]; coord_in_5 <= rq.cin[5];
    flat_x_in <= rq.fx;
    flat_y_in <= rq.fy;
    next_result <= exp_res;
    req_valid <= 1;
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  // Random request: mostly in range for the current sizes, some raw.
  function automatic conv_req_t random_request();
    conv_req_t rq;
    longint unsigned wprod, hprod;
    rq.op = 1'($urandom_range(0, 1));
    for (int i = 0; i < 6; i++) begin
      if ($urandom_range(0, 3) == 0) rq.cin[i] = COMP_BITS'($urandom);
      else rq.cin[i] = COMP_BITS'($urandom %
                                  shadow_size(i < 3 ? shadow_wsz[i] : shadow_hsz[i-3]));
    end
    wprod = 1;
    hprod = 1;
    for (int i = 0; i < shadow_count(shadow_wcnt); i++) wprod *= shadow_size(shadow_wsz[i]);
    for (int i = 0; i < shadow_count(shadow_hcnt); i++) hprod *= shadow_size(shadow_hsz[i]);
    if (wprod > (1 << FLAT_BITS)) wprod = 1 << FLAT_BITS;
    if (hprod > (1 << FLAT_BITS)) hprod = 1 << FLAT_BITS;
    if ($urandom_range(0, 3) == 0) begin
      rq.fx = FLAT_BITS'($urandom);
      rq.fy = FLAT_BITS'($urandom);
    end else begin
      rq.fx = FLAT_BITS'($urandom % wprod);
      rq.fy = FLAT_BITS'($urandom % hprod);
    end
    return rq;
  endfunction

  // Result-side stall in random bursts; none once quiet.
  initial begin
    res_stall = 0;
    @(negedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        res_stall <= 1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        res_stall <= 0;
      end
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  end

  // Record accepted requests and check accepted results at the rising edge.
  always @(posedge clk) begin
    conv_res_t want, got;
    if (!rst) begin
      if (req_valid && !req_stall) pending_results = {pending_results, next_result};
      if (res_valid && !res_stall) begin
        got = '{flat_x_out, flat_y_out,
                {coord_out_5, coord_out_4, coord_out_3, coord_out_2, coord_out_1, coord_out_0},
                overflow};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          want = pending_results.pop_front();
          if (got.fx !== want.fx || got.fy !== want.fy || got.c !== want.c
              || got.ovf !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: x %h/%h y %h/%h coord %h/%h ovf %b/%b (exp/act)",
                       want.fx, got.fx, want.fy, got.fy, want.c, got.c, want.ovf, got.ovf);
          end
        end
      end
      if ((req_valid && !req_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Watchdog on cycles without any handshake.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    stim_row_t rows [7];
    logic [SIZE_BITS-1:0] ws [3], hs [3];
    logic [CNT_BITS-1:0] wc, hc;
    conv_req_t rq;

    rst = 1;
    cfg_we = 0; cfg_index = REG_WIDTH_DIM_COUNT; cfg_data = 0;
    req_valid = 0; op = OP_FLATTEN;
    coord_in_0 = 0; coord_in_1 = 0; coord_in_2 = 0;
    coord_in_3 = 0; coord_in_4 = 0; coord_in_5 = 0;
    flat_x_in = 0; flat_y_in = 0;
    next_result = '0;
    shadow_wcnt = 1; shadow_hcnt = 1;
    for (int i = 0; i < 3; i++) begin
      shadow_wsz[i] = 1;
      shadow_hsz[i] = 1;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed rows at the reset config: one dimension per axis, size one.
    rows[0] = '{'{OP_FLATTEN, '0, '0, '0}, 1, '0};
    rows[1] = '{'{OP_FLATTEN, {6{COMP_MAX}}, '0, '0}, 1,
                '{24'd8191, 24'd8191, '0, 1'b0}};
    rows[2] = '{'{OP_UNFLATTEN, '0, FLAT_MAX, FLAT_MAX}, 1,
                '{'0, '0, {13'd0, 13'd0, COMP_MAX, 13'd0, 13'd0, COMP_MAX}, 1'b1}};
    rows[3] = '{'{OP_UNFLATTEN, '0, 24'd8191, 24'd0}, 1,
                '{'0, '0, {13'd0, 13'd0, 13'd0, 13'd0, 13'd0, COMP_MAX}, 1'b0}};
    rows[4] = '{'{OP_UNFLATTEN, {6{COMP_MAX}}, 24'd8192, 24'd3}, 1,
                '{'0, '0, {13'd0, 13'd0, 13'd3, 13'd0, 13'd0, COMP_MAX}, 1'b1}};
    rows[5] = '{'{OP_FLATTEN, {6{13'h0AAA}}, 24'h555555, 24'hAAAAAA}, 0, '0};
    rows[6] = '{'{OP_UNFLATTEN, {6{13'h1555}}, 24'h001234, 24'h000042}, 0, '0};
    foreach (rows[i])
      send_request(rows[i].rq, rows[i].typed ? rows[i].rs : convert_coord(rows[i].rq));

    // Phases: extremes of the registers and a mixed setting first, then random settings.
    for (int p = 0; p < PHASES; p++) begin
      req_valid <= 0;
      case (p)
        0: begin
          wc = CNT_THREE; hc = CNT_THREE;
          ws = '{14'd8192, 14'd8192, 14'd8192}; hs = ws;
        end
        1: begin
          wc = CNT_THREE; hc = CNT_THREE;
          ws = '{14'h3FFF, 14'h3FFF, 14'h3FFF}; hs = ws;
        end
        2: begin
          wc = 0; hc = 0;
          ws = '{14'd0, 14'd0, 14'd0}; hs = ws;
        end
        3: begin
          wc = CNT_TWO; hc = CNT_THREE;
          ws = '{14'd3, 14'd0, 14'd5}; hs = '{14'd1, 14'd7, 14'd2};
        end
        default: begin
          wc = CNT_BITS'($urandom_range(0, 3)); hc = CNT_BITS'($urandom_range(0, 3));
          for (int i = 0; i < 3; i++) begin
            ws[i] = ($urandom_range(0, 4) == 0) ? SIZE_BITS'($urandom) :
                                                  SIZE_BITS'($urandom_range(1, 200));
            hs[i] = ($urandom_range(0, 4) == 0) ? SIZE_BITS'($urandom) :
                                                  SIZE_BITS'($urandom_range(1, 200));
          end
        end
      endcase
      write_config(wc, hc, ws, hs);
      if (p == PHASES - 1) quiet = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        rq = random_request();
        send_request(rq, convert_coord(rq));
      end
    end
    req_valid <= 0;

    wait (pending_results.size() == 0);
    repeat (NUM_STAGES + 8) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
